### design/mcbg_pkg.sv
// Shared types and constants for the multi-click button gesture detector.
package mcbg_pkg;

  localparam int unsigned CountWidth = 16;
  localparam int unsigned CfgIndexWidth = 2;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [CfgIndexWidth-1:0] cfg_index_t;

  // Gesture event codes.
  typedef enum logic [1:0] {
    EV_PREVIOUS   = 2'd0,
    EV_PLAY_PAUSE = 2'd1,
    EV_NEXT       = 2'd2,
    EV_LIKE       = 2'd3
  } event_code_t;

  // Configuration register indexes.
  localparam cfg_index_t REG_HOLD_TICKS   = 2'd0;
  localparam cfg_index_t REG_GAP_TICKS    = 2'd1;
  localparam cfg_index_t REG_REPEAT_TICKS = 2'd2;

  // Reset values of the configuration registers.
  localparam count_t HOLD_TICKS_RESET   = 16'd50;
  localparam count_t GAP_TICKS_RESET    = 16'd50;
  localparam count_t REPEAT_TICKS_RESET = 16'd50;

endpackage

### design/mcbg_if.sv
// Handshake channels of the gesture detector: samples, events and configuration.
interface mcbg_sample_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

interface mcbg_event_if;
  import mcbg_pkg::*;
  logic        valid;
  logic        ready;
  event_code_t event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

interface mcbg_cfg_if;
  import mcbg_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  count_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### design/multi_click_button_gesture.sv
// Top level of the multi-click button gesture detector.
//
//   channel  | dir | payload                     | role
//   ---------+-----+-----------------------------+------------------------------
//   sample   | in  | pin_level (1b, 0 = pressed) | one button sample per request
//   gesture  | out | event_code (2b)             | zero or one event per sample
//   cfg      | in  | index (2b), data (16b)      | threshold register writes
//
// A sample request is taken every cycle unless the output stalls; it is held in the
// sample register, and its event, if any, is then loaded into the event register.
// The gesture state advances only when the event register is free or being drained,
// so a stalled event holds back the sample register and then the input.
// rst is synchronous and returns to idle with all thresholds at 50 ticks.
// Configuration writes are always taken at once.
module multi_click_button_gesture (
  input logic clk,
  input logic rst,
  mcbg_sample_if.sink   sample,
  mcbg_event_if.source  gesture,
  mcbg_cfg_if.sink      cfg
);
  import mcbg_pkg::*;

  typedef enum logic [8:0] {
    PH_IDLE      = 9'b000000001,
    PH_PRESS1    = 9'b000000010,
    PH_GAP1      = 9'b000000100,
    PH_PRESS2    = 9'b000001000,
    PH_GAP2      = 9'b000010000,
    PH_PRESS3    = 9'b000100000,
    PH_HOLD_PREV = 9'b001000000,
    PH_HOLD_NEXT = 9'b010000000,
    PH_HOLD_LIKE = 9'b100000000
  } phase_t;

  count_t hold_ticks;
  count_t gap_ticks;
  count_t repeat_ticks;

  phase_t phase;
  phase_t phase_next;
  count_t tick_count;
  count_t tick_count_next;
  logic   repeat_started;
  logic   repeat_started_next;

  logic   sample_valid;
  logic   sample_pin;
  logic   advance;

  logic        event_valid;
  event_code_t event_code;
  logic        emit;
  event_code_t emit_code;

  // Configuration registers take every write request at once.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks   <= HOLD_TICKS_RESET;
      gap_ticks    <= GAP_TICKS_RESET;
      repeat_ticks <= REPEAT_TICKS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HOLD_TICKS:   hold_ticks <= cfg.data;
        REG_GAP_TICKS:    gap_ticks <= cfg.data;
        REG_REPEAT_TICKS: repeat_ticks <= cfg.data;
        default: ;
      endcase
    end
  end

  // The held sample moves on whenever the event register can take a new value.
  assign advance      = !event_valid || gesture.ready;
  assign sample.ready = !sample_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (sample.ready) begin
      sample_valid <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.ready && sample.valid) begin
      sample_pin <= sample.pin_level;
    end
  end

  // Gesture update for one sample: phase change or tick count, then threshold tests.
  always_comb begin
    logic   pressed;
    logic   do_check;
    logic   do_count;
    count_t bumped;

    pressed             = !sample_pin;
    do_check            = 1'b0;
    do_count            = 1'b0;
    phase_next          = phase;
    tick_count_next     = tick_count;
    repeat_started_next = repeat_started;
    emit                = 1'b0;
    emit_code           = EV_PREVIOUS;
    bumped              = (tick_count == '1) ? tick_count : tick_count + count_t'(1);

    case (phase)
      PH_IDLE: begin
        if (pressed) begin
          phase_next = PH_PRESS1;
          do_check   = 1'b1;
        end
      end
      PH_PRESS1: begin
        if (!pressed) begin
          phase_next = PH_GAP1;
          do_check   = 1'b1;
        end else begin
          do_count = 1'b1;
        end
      end
      PH_GAP1: begin
        if (pressed) begin
          phase_next = PH_PRESS2;
          do_check   = 1'b1;
        end else begin
          do_count = 1'b1;
        end
      end
      PH_PRESS2: begin
        if (!pressed) begin
          phase_next = PH_GAP2;
          do_check   = 1'b1;
        end else begin
          do_count = 1'b1;
        end
      end
      PH_GAP2: begin
        if (pressed) begin
          phase_next = PH_PRESS3;
          do_check   = 1'b1;
        end else begin
          do_count = 1'b1;
        end
      end
      PH_PRESS3: begin
        if (!pressed) begin
          emit                = 1'b1;
          emit_code           = EV_LIKE;
          phase_next          = PH_IDLE;
          tick_count_next     = '0;
          repeat_started_next = 1'b0;
        end else begin
          do_count = 1'b1;
        end
      end
      PH_HOLD_PREV, PH_HOLD_NEXT: begin
        if (!pressed) begin
          phase_next          = PH_IDLE;
          tick_count_next     = '0;
          repeat_started_next = 1'b0;
        end else if (bumped >= repeat_ticks) begin
          // The first period only arms the repeat; later periods fire it.
          tick_count_next     = '0;
          repeat_started_next = 1'b1;
          if (repeat_started) begin
            emit      = 1'b1;
            emit_code = (phase == PH_HOLD_PREV) ? EV_PREVIOUS : EV_NEXT;
          end
        end else begin
          tick_count_next = bumped;
        end
      end
      PH_HOLD_LIKE: begin
        if (!pressed) begin
          phase_next          = PH_IDLE;
          tick_count_next     = '0;
          repeat_started_next = 1'b0;
        end
      end
      default: begin
        phase_next          = PH_IDLE;
        tick_count_next     = '0;
        repeat_started_next = 1'b0;
      end
    endcase

    // A new phase starts at its first tick; otherwise one more tick is counted.
    if (do_check) begin
      tick_count_next     = count_t'(1);
      repeat_started_next = 1'b0;
    end else if (do_count) begin
      tick_count_next = bumped;
      do_check        = 1'b1;
    end

    // Threshold tests of the press and gap phases.
    if (do_check) begin
      case (phase_next)
        PH_PRESS1: begin
          if (tick_count_next > hold_ticks) begin
            emit                = 1'b1;
            emit_code           = EV_PREVIOUS;
            phase_next          = PH_HOLD_PREV;
            tick_count_next     = '0;
            repeat_started_next = 1'b0;
          end
        end
        PH_GAP1: begin
          if (tick_count_next > gap_ticks) begin
            emit            = 1'b1;
            emit_code       = EV_PLAY_PAUSE;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
        end
        PH_PRESS2: begin
          if (tick_count_next > hold_ticks) begin
            emit                = 1'b1;
            emit_code           = EV_NEXT;
            phase_next          = PH_HOLD_NEXT;
            tick_count_next     = '0;
            repeat_started_next = 1'b0;
          end
        end
        PH_GAP2: begin
          if (tick_count_next > gap_ticks) begin
            emit            = 1'b1;
            emit_code       = EV_NEXT;
            phase_next      = PH_IDLE;
            tick_count_next = '0;
          end
        end
        PH_PRESS3: begin
          if (tick_count_next > hold_ticks) begin
            emit            = 1'b1;
            emit_code       = EV_LIKE;
            phase_next      = PH_HOLD_LIKE;
            tick_count_next = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Gesture state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_count     <= '0;
      repeat_started <= 1'b0;
    end else if (sample_valid && advance) begin
      phase          <= phase_next;
      tick_count     <= tick_count_next;
      repeat_started <= repeat_started_next;
    end
  end

  // Event register toward the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (advance) begin
      event_valid <= sample_valid && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && sample_valid && emit) begin
      event_code <= emit_code;
    end
  end

  assign gesture.valid      = event_valid;
  assign gesture.event_code = event_code;

endmodule
